// File: sv/pcm_mix_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PCM channel mixer.
// No dependencies; imported by every mixer module.
package pcm_mix_pkg;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	// configuration register indexes
	localparam logic [1:0] REG_MASTER_VOLUME   = 2'd0;
	localparam logic [1:0] REG_OUTPUT_FORMAT   = 2'd1;
	localparam logic [1:0] REG_OUTPUT_CHANNELS = 2'd2;
	localparam logic [1:0] REG_RING_SIZE_LOG2  = 2'd3;

	// output formats
	localparam logic [1:0] FMT_S16 = 2'd0;
	localparam logic [1:0] FMT_U8  = 2'd1;

	localparam logic [1:0] CHAN_MONO   = 2'd1;
	localparam logic [1:0] CHAN_STEREO = 2'd2;

	localparam int FACTOR_W    = 17;
	localparam int PROD_W      = 26;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// accumulator clamp before conversion: 32767*256 and -32768*256
	localparam logic signed [31:0] ACC_CLAMP_HI = 32'sd8388352;
	localparam logic signed [31:0] ACC_CLAMP_LO = -32'sd8388608;
	localparam logic signed [17:0] S16_MAX      = 18'sd32767;
	localparam logic signed [17:0] S16_MIN      = -18'sd32768;

	// one classified item waiting for the back end
	typedef struct packed {
		op_t                  op;
		logic signed [15:0]   sample;
		logic [FACTOR_W-1:0]  factor_l;
		logic [FACTOR_W-1:0]  factor_r;
		logic                 music_present;
		logic signed [23:0]   music_left;
		logic signed [23:0]   music_right;
	} qentry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} qstat_t;

	// settings the back end reads
	typedef struct packed {
		logic [1:0] output_format;
		logic       mono;
		logic [4:0] ring_log2;
	} mix_cfg_t;

endpackage

// File: sv/pcm_mix_front.sv
`timescale 1ns / 1ps
// Front end: accepts items and classifies them into queue entries,
// folding the volume and master volume into one scale factor per side.
// Depends on pcm_mix_pkg.
module pcm_mix_front import pcm_mix_pkg::*; (
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               operation,
	input  logic signed [15:0] sample_value,
	input  logic               sample_is_8bit,
	input  logic [7:0]         left_volume,
	input  logic [7:0]         right_volume,
	input  logic               music_present,
	input  logic signed [23:0] music_left,
	input  logic signed [23:0] music_right,
	input  logic [8:0]         master_volume,
	input  qstat_t             q_stat,
	output logic               push,
	output qentry_t            entry
);

	logic [7:0]  vol_l;
	logic [7:0]  vol_r;
	logic [16:0] mul_l;
	logic [16:0] mul_r;

	assign item_ready = !q_stat.full;
	assign push       = item_valid && !q_stat.full;

	// 8-bit path keeps (vol>>3)*8, 16-bit path divides the product by 256
	assign vol_l = sample_is_8bit ? {left_volume[7:3], 3'b000}  : left_volume;
	assign vol_r = sample_is_8bit ? {right_volume[7:3], 3'b000} : right_volume;
	assign mul_l = 17'(vol_l) * 17'(master_volume);
	assign mul_r = 17'(vol_r) * 17'(master_volume);

	always_comb begin
		entry.op            = op_t'(operation);
		entry.sample        = sample_is_8bit ? {{8{sample_value[7]}}, sample_value[7:0]}
		                                     : sample_value;
		entry.factor_l      = sample_is_8bit ? mul_l : {8'h00, mul_l[16:8]};
		entry.factor_r      = sample_is_8bit ? mul_r : {8'h00, mul_r[16:8]};
		entry.music_present = music_present;
		entry.music_left    = music_left;
		entry.music_right   = music_right;
	end

endmodule

// File: sv/pcm_mix_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified items between the front and back ends.
// Depends on pcm_mix_pkg.
module pcm_mix_queue import pcm_mix_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t wr_entry,
	input  logic    pop,
	output qstat_t  stat,
	output qentry_t rd_entry
);

	qentry_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign stat.not_empty = (count_q != '0);
	assign stat.full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign rd_entry       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/pcm_mix_back.sv
`timescale 1ns / 1ps
// Back end: scales and accumulates add items, converts and emits the frame
// on finish items through a one-entry output register. Depends on pcm_mix_pkg.
module pcm_mix_back import pcm_mix_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mix_cfg_t    cfg,
	input  qstat_t      q_stat,
	input  qentry_t     head,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] ring_address,
	output logic [15:0] out_sample,
	output logic        last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_EMIT_L,
		ST_EMIT_R
	} state_t;

	state_t                    state_q;
	logic signed [31:0]        left_acc_q;
	logic signed [31:0]        right_acc_q;
	logic [15:0]               frame_q;
	logic signed [PROD_W-1:0]  prod_l_s1;
	logic signed [PROD_W-1:0]  prod_r_s1;
	logic [15:0]               conv_l_q;
	logic [15:0]               conv_r_q;
	logic                      res_valid_q;
	logic [15:0]               res_addr_q;
	logic [15:0]               res_sample_q;
	logic                      res_last_q;

	logic signed [33:0]        mul_l;
	logic signed [33:0]        mul_r;
	logic [16:0]               ring_mask;
	logic [16:0]               pos_l;
	logic [16:0]               pos_r;
	logic [15:0]               addr_l;
	logic [15:0]               addr_r;
	logic                      res_free;
	logic                      res_emit;

	function automatic logic signed [31:0] sat_acc(input logic signed [31:0] acc,
	                                               input logic signed [PROD_W-1:0] p);
		logic signed [32:0] s;
		s = 33'(acc) + 33'(p);
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh80000000 : 32'sh7fffffff;
		end
		return s[31:0];
	endfunction

	// clamp, halve, add half the music, /256, saturate, format
	function automatic logic [15:0] convert_side(input logic signed [31:0] acc,
	                                             input logic music,
	                                             input logic signed [23:0] m,
	                                             input logic [1:0] fmt);
		logic signed [23:0] v;
		logic signed [24:0] vr;
		logic signed [23:0] vh;
		logic signed [24:0] mr;
		logic signed [23:0] mh;
		logic signed [24:0] hs;
		logic signed [25:0] ds;
		logic signed [17:0] q;
		logic signed [15:0] s;
		logic signed [15:0] sr;
		logic signed [7:0]  b;
		logic [15:0]        r;
		if (acc > ACC_CLAMP_HI) begin
			v = ACC_CLAMP_HI[23:0];
		end else if (acc < ACC_CLAMP_LO) begin
			v = ACC_CLAMP_LO[23:0];
		end else begin
			v = acc[23:0];
		end
		// divisions truncate toward zero: bias negatives before the shift
		vr = 25'(v) + 25'(v[23]);
		vh = 24'(vr >>> 1);
		mr = 25'(m) + 25'(m[23]);
		mh = 24'(mr >>> 1);
		hs = 25'(vh) + (music ? 25'(mh) : 25'sd0);
		ds = 26'(hs) + (hs[24] ? 26'sd255 : 26'sd0);
		q  = 18'(ds >>> 8);
		if (q > S16_MAX) begin
			s = 16'sh7fff;
		end else if (q < S16_MIN) begin
			s = 16'sh8000;
		end else begin
			s = q[15:0];
		end
		sr = s + (s[15] ? 16'sd255 : 16'sd0);
		b  = 8'(sr >>> 8);
		case (fmt)
			FMT_S16: r = s;
			FMT_U8:  r = {8'h00, ~b[7], b[6:0]};
			default: r = {{8{b[7]}}, b};
		endcase
		return r;
	endfunction

	assign pop      = (state_q == ST_IDLE) && q_stat.not_empty;
	assign res_free = !res_valid_q || result_ready;
	assign res_emit = ((state_q == ST_EMIT_L) || (state_q == ST_EMIT_R)) && res_free;

	assign mul_l = head.sample * $signed({1'b0, head.factor_l});
	assign mul_r = head.sample * $signed({1'b0, head.factor_r});

	always_comb begin
		for (int i = 0; i < 17; i++) begin
			ring_mask[i] = (5'(i) < cfg.ring_log2);
		end
	end

	assign pos_l  = cfg.mono ? {1'b0, frame_q} : {frame_q, 1'b0};
	assign pos_r  = {frame_q, 1'b1};
	assign addr_l = 16'(pos_l & ring_mask);
	assign addr_r = 16'(pos_r & ring_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			left_acc_q   <= '0;
			right_acc_q  <= '0;
			frame_q      <= '0;
			prod_l_s1    <= '0;
			prod_r_s1    <= '0;
			conv_l_q     <= '0;
			conv_r_q     <= '0;
			res_valid_q  <= 1'b0;
			res_addr_q   <= '0;
			res_sample_q <= '0;
			res_last_q   <= 1'b0;
		end else begin
			res_valid_q <= res_emit || (res_valid_q && !result_ready);
			case (state_q)
				ST_IDLE: begin
					if (q_stat.not_empty) begin
						if (head.op == OP_ADD) begin
							prod_l_s1 <= mul_l[PROD_W-1:0];
							prod_r_s1 <= mul_r[PROD_W-1:0];
							state_q   <= ST_ACC;
						end else begin
							conv_l_q <= convert_side(left_acc_q, head.music_present,
							                         head.music_left, cfg.output_format);
							conv_r_q <= convert_side(right_acc_q, head.music_present,
							                         head.music_right, cfg.output_format);
							state_q  <= ST_EMIT_L;
						end
					end
				end
				ST_ACC: begin
					left_acc_q  <= sat_acc(left_acc_q, prod_l_s1);
					right_acc_q <= sat_acc(right_acc_q, prod_r_s1);
					state_q     <= ST_IDLE;
				end
				ST_EMIT_L: begin
					if (res_free) begin
						res_addr_q   <= addr_l;
						res_sample_q <= conv_l_q;
						res_last_q   <= cfg.mono;
						if (cfg.mono) begin
							left_acc_q  <= '0;
							right_acc_q <= '0;
							frame_q     <= frame_q + 16'd1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_R;
						end
					end
				end
				ST_EMIT_R: begin
					if (res_free) begin
						res_addr_q   <= addr_r;
						res_sample_q <= conv_r_q;
						res_last_q   <= 1'b1;
						left_acc_q   <= '0;
						right_acc_q  <= '0;
						frame_q      <= frame_q + 16'd1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign ring_address = res_addr_q;
	assign out_sample   = res_sample_q;
	assign last         = res_last_q;

endmodule

// File: sv/pcm_channel_mixer.sv
`timescale 1ns / 1ps
// An accepted item is registered in the queue before it can leave it; on leaving, a finish
// item's samples are converted into registers, then pass through the output register.
// The back end sequencer takes an add item through IDLE and ACC, a finish item through
// IDLE, EMIT_L and, for stereo, EMIT_R; the emit states wait while the output register
// is held. The front takes an item every cycle while the two-entry queue has room.
// Reset clears accumulators, frame position, queue and output; registers go to defaults.
module pcm_channel_mixer import pcm_mix_pkg::*; #(
	parameter int MAX_RING_LOG2 = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes, always accepted
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// input items
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        operation,
	input  logic signed [15:0] sample_value,
	input  logic        sample_is_8bit,
	input  logic [7:0]  left_volume,
	input  logic [7:0]  right_volume,
	input  logic        music_present,
	input  logic signed [23:0] music_left,
	input  logic signed [23:0] music_right,
	// output samples
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] ring_address,
	output logic signed [15:0] out_sample,
	output logic        last
);

	localparam logic [4:0] RING_LOG2_CAP = 5'(MAX_RING_LOG2);

	// configuration registers
	logic [8:0] master_volume_q;
	logic [1:0] output_format_q;
	logic [1:0] output_channels_q;
	logic [4:0] ring_size_log2_q;

	mix_cfg_t   mix_cfg;
	qstat_t     q_stat;
	qentry_t    wr_entry;
	qentry_t    head;
	logic       q_push;
	logic       q_pop;
	logic [15:0] sample_bits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_volume_q   <= 9'd256;
			output_format_q   <= FMT_S16;
			output_channels_q <= CHAN_STEREO;
			ring_size_log2_q  <= 5'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MASTER_VOLUME:   master_volume_q   <= cfg_data;
				REG_OUTPUT_FORMAT:   output_format_q   <= cfg_data[1:0];
				REG_OUTPUT_CHANNELS: output_channels_q <= cfg_data[1:0];
				REG_RING_SIZE_LOG2:  ring_size_log2_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// anything but mono counts as stereo; ring size saturates at the cap
	always_comb begin
		mix_cfg.output_format = output_format_q;
		mix_cfg.mono          = (output_channels_q == CHAN_MONO);
		mix_cfg.ring_log2     = (ring_size_log2_q > RING_LOG2_CAP) ? RING_LOG2_CAP
		                                                           : ring_size_log2_q;
	end

	// front: handshake and per-side scale factor
	pcm_mix_front u_front (
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.operation      (operation),
		.sample_value   (sample_value),
		.sample_is_8bit (sample_is_8bit),
		.left_volume    (left_volume),
		.right_volume   (right_volume),
		.music_present  (music_present),
		.music_left     (music_left),
		.music_right    (music_right),
		.master_volume  (master_volume_q),
		.q_stat         (q_stat),
		.push           (q_push),
		.entry          (wr_entry)
	);

	// decouples the front from the back so each stalls on its own
	pcm_mix_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.stat     (q_stat),
		.rd_entry (head)
	);

	// back: multiply-accumulate, then convert and emit on finish
	pcm_mix_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (mix_cfg),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.ring_address (ring_address),
		.out_sample   (sample_bits),
		.last         (last)
	);

	assign out_sample = sample_bits;

	// the back end only takes from a queue that holds an item
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.not_empty)
		else $error("queue popped while empty");

	// the left sample of a stereo frame is followed at once by the right one
	a_stereo_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready && !last) |=> (result_valid && last))
		else $error("right sample did not follow left sample");

	// a full queue stays full while nothing is popped
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !q_pop) |=> q_stat.full)
		else $error("full queue lost an entry without a pop");

endmodule
